@@ sv/utd_pkg.sv @@
// utd_pkg: shared types and constants of the utf-8 to utf-32 decoder
// used by utd_decode and utf8_to_utf32_decoder; no dependencies
package utd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CodeW  = 21;
  localparam int unsigned LeftW  = 2;
  localparam int unsigned TdataInW  = 8;
  localparam int unsigned TdataOutW = 24;

  // lead byte classes
  localparam logic [ByteW-1:0] AsciiLimit = 8'h80;
  localparam logic [ByteW-1:0] Lead2Mask  = 8'hE0;
  localparam logic [ByteW-1:0] Lead2Code  = 8'hC0;
  localparam logic [ByteW-1:0] Lead3Mask  = 8'hF0;
  localparam logic [ByteW-1:0] Lead3Code  = 8'hE0;
  localparam logic [ByteW-1:0] Lead4Mask  = 8'hF8;
  localparam logic [ByteW-1:0] Lead4Code  = 8'hF0;

  // payload masks and follower counts
  localparam logic [ByteW-1:0] Pay2Mask = 8'h1F;
  localparam logic [ByteW-1:0] Pay3Mask = 8'h0F;
  localparam logic [ByteW-1:0] Pay4Mask = 8'h07;
  localparam logic [ByteW-1:0] FollowMask = 8'h3F;
  localparam logic [LeftW-1:0] Follow2 = 2'd1;
  localparam logic [LeftW-1:0] Follow3 = 2'd2;
  localparam logic [LeftW-1:0] Follow4 = 2'd3;
  localparam logic [LeftW-1:0] NoFollow = 2'd0;

  localparam logic [CodeW-1:0] ReplacementChar = 21'h00FFFD;

  // decoder state carried between bytes
  typedef struct packed {
    logic [LeftW-1:0] left;
    logic [CodeW-1:0] partial;
  } utd_state_t;

  // result of decoding one byte
  typedef struct packed {
    logic             emit;
    logic [CodeW-1:0] code;
    logic             final_pt;
    utd_state_t       state;
  } utd_result_t;

endpackage

@@ sv/utf8_to_utf32_decoder.sv @@
// utf8_to_utf32_decoder: top level, input register, decode and result register
// depends on utd_pkg and utd_decode
//
//  channel | ports            | tdata / tuser / tlast
//  --------+------------------+------------------------------------------
//  in      | in_tvalid/tready | tdata[7:0] text_byte, tlast end_of_text
//  out     | out_tvalid/tready| tdata[20:0] code_point (23:21 zero),
//          |                  | tlast final_point
//
// one byte per cycle sustained while the output is not stalled; each result passes
// through the input register, then decode into the result register
// a non-last byte that starts or continues a sequence gives no result, freeing its slot
// synchronous active-low reset clears the valid flags and the decoder state
// a stalled output holds the pipeline; in_tready drops only while both
// registers are full and out_tready is low
module utf8_to_utf32_decoder
  import utd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [TdataInW-1:0]  in_tdata,   // [7:0] text_byte
  input  logic                 in_tlast,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [TdataOutW-1:0] out_tdata,  // [20:0] code_point, [23:21] zero
  output logic                 out_tlast
);

  logic             in_valid_r;
  logic [ByteW-1:0] in_byte_r;
  logic             in_last_r;
  utd_state_t       state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CodeW-1:0] out_code_r;
  logic             out_last_r;
  utd_result_t      dec;
  logic             adv;
  logic             dec_fire;

  // pipeline moves when the result slot is free or being drained
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || adv;
  assign dec_fire  = in_valid_r && adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata[ByteW-1:0];
      in_last_r <= in_tlast;
    end
  end

  utd_decode u_decode (
    .state_i     (state_r),
    .text_byte   (in_byte_r),
    .end_of_text (in_last_r),
    .res_o       (dec)
  );

  // next state and next result valid
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (dec_fire) begin
      state_nxt     = dec.state;
      out_valid_nxt = dec.emit;
    end
  end

  // decoder state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (dec_fire && dec.emit) begin
      out_code_r <= dec.code;
      out_last_r <= dec.final_pt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(TdataOutW-CodeW){1'b0}}, out_code_r};
  assign out_tlast  = out_last_r;

  // a last byte always produces a final result
  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (dec_fire && in_last_r) |=> (out_valid_r && out_last_r))
    else $error("last byte did not produce a final result");

  // no followers pending means no partial code kept
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.left == NoFollow) |-> (state_r.partial == '0))
    else $error("partial code left over with no followers pending");

  // a four-byte lead holds at most three payload bits
  a_lead4_width: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.left == Follow4) |-> (state_r.partial[CodeW-1:3] == '0))
    else $error("four-byte lead payload too wide");

  // state is cleared after the end of a text
  a_eot_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (dec_fire && in_last_r) |=> (state_r == '0))
    else $error("state not cleared at end of text");

endmodule

@@ sv/utd_decode.sv @@
// utd_decode: combinational decode of one text byte against the current state
// depends on utd_pkg
module utd_decode
  import utd_pkg::*;
(
  input  utd_state_t       state_i,
  input  logic [ByteW-1:0] text_byte,
  input  logic             end_of_text,
  output utd_result_t      res_o
);

  always_comb begin
    res_o          = '0;
    res_o.state    = state_i;
    res_o.final_pt = end_of_text;
    if (state_i.left == NoFollow) begin
      // lead byte position
      if (text_byte < AsciiLimit) begin
        res_o.emit = 1'b1;
        res_o.code = {{(CodeW-ByteW){1'b0}}, text_byte};
      end else if ((text_byte & Lead2Mask) == Lead2Code) begin
        res_o.state.partial = {{(CodeW-ByteW){1'b0}}, text_byte & Pay2Mask};
        res_o.state.left    = Follow2;
      end else if ((text_byte & Lead3Mask) == Lead3Code) begin
        res_o.state.partial = {{(CodeW-ByteW){1'b0}}, text_byte & Pay3Mask};
        res_o.state.left    = Follow3;
      end else if ((text_byte & Lead4Mask) == Lead4Code) begin
        res_o.state.partial = {{(CodeW-ByteW){1'b0}}, text_byte & Pay4Mask};
        res_o.state.left    = Follow4;
      end else begin
        res_o.emit = 1'b1;
        res_o.code = ReplacementChar;
      end
    end else begin
      // follower position, top bits not checked
      res_o.state.partial = {state_i.partial[CodeW-7:0], text_byte[5:0]};
      res_o.state.left    = state_i.left - 2'd1;
      if (res_o.state.left == NoFollow) begin
        res_o.emit          = 1'b1;
        res_o.code          = res_o.state.partial;
        res_o.state.partial = '0;
      end
    end
    // end of text flushes a partial sequence
    if (end_of_text && !res_o.emit) begin
      res_o.emit = 1'b1;
      res_o.code = res_o.state.partial;
    end
    if (end_of_text) begin
      res_o.state = '0;
    end
  end

endmodule
